@@ src/tlpwp_pkg.sv @@
// package for the three-level priority work pool
// item types, controller command type and shared constants; no dependencies

package tlpwp_pkg;

  localparam int LEVEL_DEPTH_DEF = 64;
  localparam int WORD_WIDTH_DEF  = 64;

  localparam int NUM_LEVELS   = 3;
  localparam int LIMIT_FACTOR = 10;
  localparam int LIMIT_W      = 12;
  localparam int WORD_BITS    = 64;
  localparam int COUNT_BITS   = 8;
  localparam int THRESH_BITS  = 8;

  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 8'd4;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] LVL_HIGH   = 2'd0;
  localparam logic [1:0] LVL_NORMAL = 2'd1;
  localparam logic [1:0] LVL_LOW    = 2'd2;
  localparam logic [1:0] LVL_NONE   = 2'd3;

  typedef struct packed {
    logic                 func;
    logic [1:0]           level;
    logic [WORD_BITS-1:0] task_word;
  } in_item_t;

  typedef struct packed {
    logic                  popped;
    logic [WORD_BITS-1:0]  popped_word;
    logic [1:0]            popped_level;
    logic                  dropped;
    logic [COUNT_BITS-1:0] total_count;
    logic                  is_empty;
    logic                  is_emptying;
    logic                  over_limit;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

@@ src/tlpwp_ctrl.sv @@
// controller state machine for the work pool
// sequences capture, execute and result cycles; uses tlpwp_pkg

module tlpwp_ctrl
  import tlpwp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_DONE);
  assign cmd.capture = (state == S_IDLE) && start;
  assign cmd.exec    = (state == S_EXEC);

endmodule

@@ src/tlpwp_datapath.sv @@
// datapath of the work pool: task store, per-level fifo pointers and counts,
// threshold register and result status logic; uses tlpwp_pkg

module tlpwp_datapath
  import tlpwp_pkg::*;
#(
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  in_item_t               request,
  input  logic                   cfg_we,
  input  logic [THRESH_BITS-1:0] cfg_data,
  output out_item_t              result
);

  localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int PTR_W     = $clog2(LEVEL_DEPTH);
  localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int POOL_W    = $clog2(MEM_DEPTH + 1);
  localparam int CMP_W     = (POOL_W > LIMIT_W) ? POOL_W : LIMIT_W;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    advance = (ptr == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  logic                   func_q;
  logic [1:0]             level_q;
  logic [WORD_WIDTH-1:0]  word_q;
  logic [PTR_W-1:0]       head [NUM_LEVELS];
  logic [PTR_W-1:0]       tail [NUM_LEVELS];
  logic [CNT_W-1:0]       count [NUM_LEVELS];
  logic [POOL_W-1:0]      pool_count;
  logic [THRESH_BITS-1:0] threshold;
  logic [WORD_WIDTH-1:0]  mem [MEM_DEPTH];
  logic [WORD_WIDTH-1:0]  rd_data;
  logic                   popped_q;
  logic [1:0]             popped_level_q;
  logic                   dropped_q;

  logic [NUM_LEVELS-1:0]  full;
  logic [NUM_LEVELS-1:0]  push_sel;
  logic [NUM_LEVELS-1:0]  pop_sel;
  logic                   push_ok;
  logic                   pop_ok;
  logic [ADDR_W-1:0]      addr;
  logic [1:0]             pop_level;
  logic                   found;
  logic [LIMIT_W-1:0]     limit;

  always_comb begin
    found     = 1'b0;
    addr      = '0;
    pop_level = LVL_HIGH;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      full[l]     = (count[l] == CNT_W'(LEVEL_DEPTH));
      push_sel[l] = (func_q == FUNC_PUSH) && (level_q == 2'(l)) && !full[l];
      pop_sel[l]  = (func_q == FUNC_POP) && (count[l] != '0) && !found;
      if (pop_sel[l]) begin
        found     = 1'b1;
        pop_level = 2'(l);
        addr      = ADDR_W'(l * LEVEL_DEPTH) + ADDR_W'(head[l]);
      end
      if (push_sel[l]) begin
        addr = ADDR_W'(l * LEVEL_DEPTH) + ADDR_W'(tail[l]);
      end
    end
    push_ok = |push_sel;
    pop_ok  = |pop_sel;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q  <= request.func;
      level_q <= request.level;
      word_q  <= request.task_word[WORD_WIDTH-1:0];
    end
  end

  // task store
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (push_ok) mem[addr] <= word_q;
      rd_data <= mem[addr];
    end
  end

  // fifo bookkeeping and threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        count[l] <= '0;
      end
      pool_count     <= '0;
      threshold      <= THRESHOLD_RESET;
      popped_q       <= 1'b0;
      popped_level_q <= LVL_HIGH;
      dropped_q      <= 1'b0;
    end else begin
      if (cfg_we) threshold <= cfg_data;
      if (cmd.exec) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          if (push_sel[l]) begin
            tail[l]  <= advance(tail[l]);
            count[l] <= count[l] + CNT_W'(1);
          end
          if (pop_sel[l]) begin
            head[l]  <= advance(head[l]);
            count[l] <= count[l] - CNT_W'(1);
          end
        end
        if (push_ok) pool_count <= pool_count + POOL_W'(1);
        if (pop_ok)  pool_count <= pool_count - POOL_W'(1);
        popped_q       <= pop_ok;
        popped_level_q <= pop_ok ? pop_level : LVL_HIGH;
        dropped_q      <= (func_q == FUNC_PUSH) && !push_ok;
      end
    end
  end

  assign limit = LIMIT_W'(threshold) * LIMIT_W'(LIMIT_FACTOR);

  always_comb begin
    result              = '0;
    result.popped       = popped_q;
    result.popped_word  = popped_q ? WORD_BITS'(rd_data) : '0;
    result.popped_level = popped_level_q;
    result.dropped      = dropped_q;
    result.total_count  = COUNT_BITS'(pool_count);
    result.is_empty     = (pool_count == '0);
    result.is_emptying  = CMP_W'(pool_count) < CMP_W'(threshold);
    result.over_limit   = CMP_W'(pool_count) > CMP_W'(limit);
  end

endmodule

@@ src/three_level_priority_work_pool.sv @@
// top level of the three-level priority work pool
// joins tlpwp_ctrl and tlpwp_datapath; uses tlpwp_pkg
//
//   channel   ports                      transfer
//   input     start, busy, request       start high while busy low
//   result    done, result               one cycle per transaction, no backpressure
//   config    cfg_we, cfg_data           any edge with cfg_we high
//
// every transaction goes through capture, fifo update with store
// access, then the result cycle, which follows because the store read is registered
// busy is high from the accepting edge until the result cycle ends
// synchronous reset empties all levels and loads the threshold with 4
// the task store needs no clearing after reset
// results cannot be stalled; done is high for exactly one cycle per transaction

module three_level_priority_work_pool
  import tlpwp_pkg::*;
#(
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               request,
  output logic                   done,
  output out_item_t              result,
  input  logic                   cfg_we,
  input  logic [THRESH_BITS-1:0] cfg_data
);

  cmd_t cmd;

  tlpwp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  tlpwp_datapath #(
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule
